@@ rtl/assert_macros.svh @@
// Assertion macros shared by the segmenter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DPS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/dps_pkg.sv @@
// Types and constants of the double peak segmenter.
`default_nettype none

package dps_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 32;
   localparam int LENGTH_W = 17;
   localparam int CSR_IDX_W = 3;
   localparam int LATE_SHIFT = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIP_THR      = 3'd0,
      CSR_DIP_END_THR  = 3'd1,
      CSR_REC_STOP_THR = 3'd2,
      CSR_MIN_GAP      = 3'd3,
      CSR_MAX_GAP      = 3'd4,
      CSR_MAX_REC_LEN  = 3'd5
   } csr_index_type;

   localparam logic [15:0] RST_DIP_THR      = 16'd0;
   localparam logic [15:0] RST_DIP_END_THR  = 16'd0;
   localparam logic [15:0] RST_REC_STOP_THR = 16'd0;
   localparam logic [15:0] RST_MIN_GAP      = 16'd10;
   localparam logic [15:0] RST_MAX_GAP      = 16'd100;
   localparam logic [15:0] RST_MAX_REC_LEN  = 16'd512;

   typedef enum logic [6:0] {
      PH_QUIET   = 7'b0000001,
      PH_SEARCH1 = 7'b0000010,
      PH_DIP1    = 7'b0000100,
      PH_SEARCH2 = 7'b0001000,
      PH_DIP2    = 7'b0010000,
      PH_RECORD  = 7'b0100000,
      PH_RECOG   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] dip_threshold;
      logic [SAMPLE_W-1:0] dip_end_threshold;
      logic [SAMPLE_W-1:0] record_stop_threshold;
      logic [15:0]         min_gap;
      logic [15:0]         max_gap;
      logic [15:0]         max_record_length;
   } cfg_type;

   typedef struct packed {
      logic                segment_found;
      logic [COUNT_W-1:0]  segment_start;
      logic [LENGTH_W-1:0] segment_length;
      logic                sample_taken;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/dps_if.sv @@
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface dps_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic signed [dps_pkg::SAMPLE_W-1:0] sample_value;

   modport source (output valid, output func, output sample_value, input ready);
   modport sink (input valid, input func, input sample_value, output ready);
endinterface

interface dps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          segment_found;
   logic [dps_pkg::COUNT_W-1:0]   segment_start;
   logic [dps_pkg::LENGTH_W-1:0]  segment_length;
   logic                          sample_taken;

   modport source (output valid, output segment_found, output segment_start,
                   output segment_length, output sample_taken, input ready);
   modport sink (input valid, input segment_found, input segment_start,
                 input segment_length, input sample_taken, output ready);
endinterface

`default_nettype wire

@@ rtl/dps_csr.sv @@
// Configuration registers of the segmenter.
`default_nettype none

module dps_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [dps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                   csr_wdata,
   output dps_pkg::cfg_type                   cfg
);

   dps_pkg::cfg_type cfg_ff;
   dps_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            dps_pkg::CSR_DIP_THR:      cfg_in.dip_threshold         = csr_wdata;
            dps_pkg::CSR_DIP_END_THR:  cfg_in.dip_end_threshold     = csr_wdata;
            dps_pkg::CSR_REC_STOP_THR: cfg_in.record_stop_threshold = csr_wdata;
            dps_pkg::CSR_MIN_GAP:      cfg_in.min_gap               = csr_wdata;
            dps_pkg::CSR_MAX_GAP:      cfg_in.max_gap               = csr_wdata;
            dps_pkg::CSR_MAX_REC_LEN:  cfg_in.max_record_length     = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dip_threshold         <= dps_pkg::RST_DIP_THR;
         cfg_ff.dip_end_threshold     <= dps_pkg::RST_DIP_END_THR;
         cfg_ff.record_stop_threshold <= dps_pkg::RST_REC_STOP_THR;
         cfg_ff.min_gap               <= dps_pkg::RST_MIN_GAP;
         cfg_ff.max_gap               <= dps_pkg::RST_MAX_GAP;
         cfg_ff.max_record_length     <= dps_pkg::RST_MAX_REC_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/dps_core.sv @@
// Phase tracker, counters and result computation for one word.
`default_nettype none

module dps_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dps_pkg::cfg_type              cfg,
   input  wire logic                          step_en,
   input  wire logic                          func,
   input  wire logic [dps_pkg::SAMPLE_W-1:0]  sample_value,
   output dps_pkg::rsp_type                   result
);

   localparam int CW = dps_pkg::COUNT_W;
   localparam int LW = dps_pkg::LENGTH_W;

   dps_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      sample_count_ff, sample_count_in;
   logic [LW-1:0]      record_length_ff, record_length_in;
   logic [CW-1:0]      first_dip_ff, first_dip_in;

   logic [CW-1:0] gap;
   logic [17:0]   late_limit;
   logic          gap_gt_max, gap_lt_min, gap_gt_late;
   logic [LW-1:0] rl_inc;
   logic [CW-1:0] count_inc;
   logic          above_dip, below_dip, above_end, below_stop;
   logic          found, taken;

   always_comb begin
      gap         = sample_count_ff - first_dip_ff;
      late_limit  = {2'b00, cfg.min_gap} << dps_pkg::LATE_SHIFT;
      gap_gt_max  = gap > {16'd0, cfg.max_gap};
      gap_lt_min  = gap < {16'd0, cfg.min_gap};
      gap_gt_late = gap > {14'd0, late_limit};
      rl_inc      = record_length_ff + {{(LW-1){1'b0}}, 1'b1};
      count_inc   = sample_count_ff + {{(CW-1){1'b0}}, 1'b1};
      above_dip   = $signed(sample_value) > $signed(cfg.dip_threshold);
      below_dip   = $signed(sample_value) < $signed(cfg.dip_threshold);
      above_end   = $signed(sample_value) > $signed(cfg.dip_end_threshold);
      below_stop  = $signed(sample_value) < $signed(cfg.record_stop_threshold);

      phase_in         = phase_ff;
      sample_count_in  = sample_count_ff;
      record_length_in = record_length_ff;
      first_dip_in     = first_dip_ff;
      found            = 1'b0;
      taken            = 1'b1;

      if (func) begin
         // drop the held or partial segment
         sample_count_in  = sample_count_ff + {{(CW-LW){1'b0}}, record_length_ff};
         record_length_in = '0;
         first_dip_in     = '0;
         phase_in         = dps_pkg::PH_QUIET;
         taken            = 1'b0;
      end else begin
         case (phase_ff)
            dps_pkg::PH_QUIET: begin
               if (above_dip) phase_in = dps_pkg::PH_SEARCH1;
               sample_count_in = count_inc;
            end
            dps_pkg::PH_SEARCH1: begin
               if (below_dip) begin
                  phase_in     = dps_pkg::PH_DIP1;
                  first_dip_in = sample_count_ff;
               end
               sample_count_in = count_inc;
            end
            dps_pkg::PH_DIP1: begin
               if (above_end) phase_in = dps_pkg::PH_SEARCH2;
               else if (gap_gt_max) phase_in = dps_pkg::PH_QUIET;
               sample_count_in = count_inc;
            end
            dps_pkg::PH_SEARCH2: begin
               if (below_dip) begin
                  phase_in = gap_lt_min ? dps_pkg::PH_QUIET : dps_pkg::PH_DIP2;
               end else if (gap_gt_max) begin
                  phase_in = dps_pkg::PH_QUIET;
               end
               sample_count_in = count_inc;
            end
            dps_pkg::PH_DIP2: begin
               if (gap_gt_late) phase_in = dps_pkg::PH_QUIET;
               else if (above_end) phase_in = dps_pkg::PH_RECORD;
               sample_count_in = count_inc;
            end
            dps_pkg::PH_RECORD: begin
               record_length_in = rl_inc;
               if (rl_inc > {1'b0, cfg.max_record_length}) begin
                  sample_count_in  = sample_count_ff + {{(CW-LW){1'b0}}, rl_inc};
                  record_length_in = '0;
                  first_dip_in     = '0;
                  phase_in         = dps_pkg::PH_QUIET;
               end else if (below_stop) begin
                  phase_in = dps_pkg::PH_RECOG;
                  found    = 1'b1;
               end
            end
            dps_pkg::PH_RECOG: begin
               found = 1'b1;
               taken = 1'b0;
            end
            default: begin
               phase_in = dps_pkg::PH_QUIET;
            end
         endcase
      end

      result.segment_found  = found;
      result.segment_start  = found ? sample_count_ff : '0;
      result.segment_length = found ? record_length_in : '0;
      result.sample_taken   = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= dps_pkg::PH_QUIET;
         sample_count_ff  <= '0;
         record_length_ff <= '0;
         first_dip_ff     <= '0;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         sample_count_ff  <= sample_count_in;
         record_length_ff <= record_length_in;
         first_dip_ff     <= first_dip_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/double_peak_segmenter_top.sv @@
// Top level of the double peak segmenter: word registers, core and registers.
// An accepted word waits in the input register until its result can be registered.
// Throughput: one word per cycle unless stalled; the input and result registers
// each hold one word, so a stalled result still lets one more word in.
// Reset: synchronous, active high; clears phase, counters, valid flags and
// loads the configuration reset values.
`default_nettype none
`include "assert_macros.svh"

module double_peak_segmenter_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   dps_req_if.sink                            req_ch,
   dps_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_wr_en,
   input  wire logic [dps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                   csr_wdata
);

   dps_pkg::cfg_type cfg;
   dps_pkg::rsp_type core_result;

   logic                          in_valid_ff, in_valid_in;
   logic                          in_func_ff;
   logic [dps_pkg::SAMPLE_W-1:0]  in_sample_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   dps_pkg::rsp_type              rsp_data_ff;
   logic                          advance;
   logic                          req_fire;
   logic                          full_stall;
   logic                          bare_word;
   logic                          fields_clear;

   dps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dps_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step_en      (advance),
      .func         (in_func_ff),
      .sample_value (in_sample_ff),
      .result       (core_result)
   );

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_func_ff   <= req_ch.func;
         in_sample_ff <= req_ch.sample_value;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.segment_found  = rsp_data_ff.segment_found;
   assign rsp_ch.segment_start  = rsp_data_ff.segment_start;
   assign rsp_ch.segment_length = rsp_data_ff.segment_length;
   assign rsp_ch.sample_taken   = rsp_data_ff.sample_taken;

   assign full_stall   = in_valid_ff && rsp_valid_ff && !rsp_ch.ready;
   assign bare_word    = rsp_ch.valid && !rsp_ch.segment_found;
   assign fields_clear = rsp_ch.segment_start == '0 && rsp_ch.segment_length == '0;

   `DPS_ASSERT(a_full_stall_blocks, full_stall |-> !req_ch.ready, "input taken while stalled")
   `DPS_ASSERT(a_advance_shows, advance |=> rsp_ch.valid, "computed word not presented")
   `DPS_ASSERT(a_notfound_zero, bare_word |-> fields_clear, "fields set without a segment")
   `DPS_ASSERT_ALWAYS(a_reset_empty, reset |=> !(rsp_valid_ff || in_valid_ff), "word after reset")

endmodule

`default_nettype wire
